// File: hdl/bqb_pkg.sv
// bqb_pkg: shared types, constants and helpers for the bayer quad binning block
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package bqb_pkg;

    // datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = 17;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = 34;
    localparam int SUMG_W     = 19;
    localparam int SUMO_W     = 36;
    localparam int TOTAL_W    = 37;
    localparam int OP_W       = 32;
    localparam int SCALE_W    = 24;
    localparam int SPROD_W    = 56;
    localparam int RSUM_W     = 57;
    localparam int RND_W      = 18;
    localparam int PIX_W      = 16;
    localparam int LANES      = 4;
    localparam int CH_W       = 2;
    localparam int Q12_SHIFT  = 12;

    // pipeline depth: three lane stages, merge, three scale stages
    localparam int PIPE_STAGES = 7;

    // configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;

    // default for the sample width parameter
    localparam int SAMPLE_BITS_DEF = 16;

    // rounding and divide-by-three constants
    localparam logic [RND_W-1:0] RND_CLAMP  = RND_W'(196608);
    localparam logic [RND_W-1:0] DIV3_RECIP = RND_W'(174763);
    localparam int               DIV3_SHIFT = 19;
    localparam logic [PIX_W-1:0] PIX_MAX    = '1;

    // cfa channel codes
    typedef enum logic [CH_W-1:0] {
        CH_R  = 2'd0,
        CH_G  = 2'd1,
        CH_B  = 2'd2,
        CH_G2 = 2'd3
    } chan_t;

    // register indexes
    typedef enum logic [2:0] {
        REG_LUMA_MODE    = 3'd0,
        REG_CFA_PATTERN  = 3'd1,
        REG_BLACK_LEVELS = 3'd2,
        REG_GAIN_RED     = 3'd3,
        REG_GAIN_BLUE    = 3'd4,
        REG_GREEN_SAT    = 3'd5,
        REG_OUTPUT_SCALE = 3'd6
    } reg_idx_t;

    // final rounding step selection
    typedef enum logic [2:0] {
        RND_SH16,
        RND_SH17,
        RND_SH18,
        RND_SH30,
        RND_DIV3
    } rnd_t;

    // register reset values
    localparam logic                  RST_LUMA_MODE    = 1'b0;
    localparam logic [7:0]            RST_CFA_PATTERN  = 8'd180;
    localparam logic [63:0]           RST_BLACK_LEVELS = 64'd0;
    localparam logic [GAIN_W-1:0]     RST_GAIN_RED     = 16'd4096;
    localparam logic [GAIN_W-1:0]     RST_GAIN_BLUE    = 16'd4096;
    localparam logic [SAMPLE_W-1:0]   RST_GREEN_SAT    = 16'd65535;
    localparam logic [SCALE_W-1:0]    RST_OUTPUT_SCALE = 24'd65536;

    // configuration seen by the datapath
    typedef struct packed {
        logic                 luma_mode;
        logic [7:0]           cfa_pattern;
        logic [63:0]          black_levels;
        logic [GAIN_W-1:0]    gain_red;
        logic [GAIN_W-1:0]    gain_blue;
        logic [SAMPLE_W-1:0]  green_saturation;
        logic [SCALE_W-1:0]   output_scale;
    } cfg_t;

    // per lane result: green difference and equalized red/blue term (two's complement)
    typedef struct packed {
        logic [DIFF_W-1:0] dg;
        logic [PROD_W-1:0] e;
    } lane_res_t;

    // merged operand handed to the scaling stages
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            zero;
        rnd_t            rnd;
    } scale_op_t;

    function automatic logic is_green(chan_t ch);
        return (ch == CH_G) || (ch == CH_G2);
    endfunction

endpackage

// File: hdl/bqb_regs.sv
// bqb_regs: apb-style configuration register file
// depends on bqb_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps

module bqb_regs
    import bqb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.luma_mode        <= RST_LUMA_MODE;
            cfg_reg.cfa_pattern      <= RST_CFA_PATTERN;
            cfg_reg.black_levels     <= RST_BLACK_LEVELS;
            cfg_reg.gain_red         <= RST_GAIN_RED;
            cfg_reg.gain_blue        <= RST_GAIN_BLUE;
            cfg_reg.green_saturation <= RST_GREEN_SAT;
            cfg_reg.output_scale     <= RST_OUTPUT_SCALE;
        end
        else if (wr)
        begin
            case (idx)
                REG_LUMA_MODE:    cfg_reg.luma_mode        <= pwdata[0];
                REG_CFA_PATTERN:  cfg_reg.cfa_pattern      <= pwdata[7:0];
                REG_BLACK_LEVELS: cfg_reg.black_levels     <= pwdata;
                REG_GAIN_RED:     cfg_reg.gain_red         <= pwdata[GAIN_W-1:0];
                REG_GAIN_BLUE:    cfg_reg.gain_blue        <= pwdata[GAIN_W-1:0];
                REG_GREEN_SAT:    cfg_reg.green_saturation <= pwdata[SAMPLE_W-1:0];
                REG_OUTPUT_SCALE: cfg_reg.output_scale     <= pwdata[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_LUMA_MODE:    prdata = CFG_DATA_W'(cfg_reg.luma_mode);
            REG_CFA_PATTERN:  prdata = CFG_DATA_W'(cfg_reg.cfa_pattern);
            REG_BLACK_LEVELS: prdata = cfg_reg.black_levels;
            REG_GAIN_RED:     prdata = CFG_DATA_W'(cfg_reg.gain_red);
            REG_GAIN_BLUE:    prdata = CFG_DATA_W'(cfg_reg.gain_blue);
            REG_GREEN_SAT:    prdata = CFG_DATA_W'(cfg_reg.green_saturation);
            REG_OUTPUT_SCALE: prdata = CFG_DATA_W'(cfg_reg.output_scale);
            default:          prdata = '0;
        endcase
    end

endmodule

// File: hdl/bqb_lane.sv
// bqb_lane: one quad position: black subtract, gain multiply, saturation clip
// depends on bqb_pkg; three registered stages advanced by en
`timescale 1ns / 1ps

module bqb_lane
    import bqb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LANE        = 0
)
(
    input  logic                clk,
    input  logic [2:0]          en,
    input  cfg_t                cfg,
    input  logic [SAMPLE_W-1:0] sample,
    output lane_res_t           res
);

    localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    chan_t                     ch;
    logic [SAMPLE_W-1:0]       black;
    logic signed [DIFF_W-1:0]  d_next;
    logic signed [DIFF_W-1:0]  d_reg;
    chan_t                     ch_reg;
    logic [GAIN_W-1:0]         gain;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      grn_reg;
    logic signed [DIFF_W-1:0]  dg_reg;
    logic signed [PROD_W-1:0]  sat_q12;
    logic signed [PROD_W-1:0]  e_next;
    lane_res_t                 res_reg;

    assign ch    = chan_t'(cfg.cfa_pattern[CH_W*LANE +: CH_W]);
    assign black = cfg.black_levels[SAMPLE_W*ch +: SAMPLE_W];

    // stage 0: black level subtract
    assign d_next = $signed({1'b0, sample & SMASK}) - $signed({1'b0, black});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg  <= d_next;
            ch_reg <= ch;
        end
    end

    // stage 1: red or blue gain multiply
    assign gain      = (ch_reg == CH_R) ? cfg.gain_red : cfg.gain_blue;
    assign prod_next = d_reg * $signed({1'b0, gain});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_reg <= prod_next;
            grn_reg  <= is_green(ch_reg);
            dg_reg   <= is_green(ch_reg) ? d_reg : '0;
        end
    end

    // stage 2: zero the term for green lanes, else clip it from above at the green saturation
    assign sat_q12 = $signed({6'b0, cfg.green_saturation, 12'b0});

    always_comb
    begin
        if (grn_reg)
        begin
            e_next = '0;
        end
        else if (prod_reg > sat_q12)
        begin
            e_next = sat_q12;
        end
        else
        begin
            e_next = prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            res_reg.dg <= dg_reg;
            res_reg.e  <= e_next;
        end
    end

    assign res = res_reg;

endmodule

// File: hdl/bqb_merge.sv
// bqb_merge: sums the lane results and picks the operand and rounding for scaling
// depends on bqb_pkg; one registered stage advanced by en
`timescale 1ns / 1ps

module bqb_merge
    import bqb_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  cfg_t      cfg,
    input  lane_res_t res [LANES],
    output scale_op_t sop
);

    logic signed [SUMG_W-1:0]  sum_g;
    logic signed [SUMO_W-1:0]  sum_o;
    logic signed [TOTAL_W-1:0] total;
    logic [2:0]                n_g;
    scale_op_t                 sop_next;
    scale_op_t                 sop_reg;

    // lane sums and green count
    always_comb
    begin
        sum_g = '0;
        sum_o = '0;
        n_g   = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_g = sum_g + SUMG_W'($signed(res[i].dg));
            sum_o = sum_o + SUMO_W'($signed(res[i].e));
            n_g   = n_g + 3'(is_green(chan_t'(cfg.cfa_pattern[CH_W*i +: CH_W])));
        end
        total = (TOTAL_W'(sum_g) <<< Q12_SHIFT) + TOTAL_W'(sum_o);
    end

    // operand and rounding choice
    always_comb
    begin
        if (cfg.luma_mode)
        begin
            sop_next.op   = OP_W'(total);
            sop_next.zero = (total <= 0);
            sop_next.rnd  = RND_SH30;
        end
        else
        begin
            sop_next.op   = OP_W'(sum_g);
            sop_next.zero = (n_g == 3'd0) || (sum_g <= 0);
            case (n_g)
                3'd1:    sop_next.rnd = RND_SH16;
                3'd2:    sop_next.rnd = RND_SH17;
                3'd3:    sop_next.rnd = RND_DIV3;
                default: sop_next.rnd = RND_SH18;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sop_reg <= sop_next;
        end
    end

    assign sop = sop_reg;

endmodule

// File: hdl/bqb_scale.sv
// bqb_scale: output scale multiply, round half up, divide by three and clamp
// depends on bqb_pkg; three registered stages advanced by en, last one is the output
`timescale 1ns / 1ps

module bqb_scale
    import bqb_pkg::*;
(
    input  logic             clk,
    input  logic [2:0]       en,
    input  cfg_t             cfg,
    input  scale_op_t        sop,
    output logic [PIX_W-1:0] pixel
);

    logic [SPROD_W-1:0]        prod_reg;
    logic                      zero4_reg;
    rnd_t                      rnd4_reg;
    logic [RSUM_W-1:0]         rsum;
    logic [RSUM_W-1:0]         rshift;
    logic [RND_W-1:0]          rc_next;
    logic [RND_W-1:0]          rc_reg;
    logic                      zero5_reg;
    logic                      div3_reg;
    logic [2*RND_W-1:0]        recip_prod;
    logic [RND_W-1:0]          q;
    logic [PIX_W-1:0]          pixel_next;
    logic [PIX_W-1:0]          pixel_reg;

    // stage 4: scale multiply
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg  <= SPROD_W'(sop.op) * SPROD_W'(cfg.output_scale);
            zero4_reg <= sop.zero;
            rnd4_reg  <= sop.rnd;
        end
    end

    // stage 5: add half and shift, then clamp to a narrow range
    always_comb
    begin
        case (rnd4_reg)
            RND_SH16:
            begin
                rsum   = RSUM_W'(prod_reg) + (RSUM_W'(1) << 15);
                rshift = rsum >> 16;
            end
            RND_SH17:
            begin
                rsum   = RSUM_W'(prod_reg) + (RSUM_W'(1) << 16);
                rshift = rsum >> 17;
            end
            RND_SH18:
            begin
                rsum   = RSUM_W'(prod_reg) + (RSUM_W'(1) << 17);
                rshift = rsum >> 18;
            end
            RND_SH30:
            begin
                rsum   = RSUM_W'(prod_reg) + (RSUM_W'(1) << 29);
                rshift = rsum >> 30;
            end
            RND_DIV3:
            begin
                rsum   = RSUM_W'(prod_reg) + (RSUM_W'(3) << 15);
                rshift = rsum >> 16;
            end
            default:
            begin
                rsum   = RSUM_W'(prod_reg);
                rshift = rsum >> 16;
            end
        endcase
        rc_next = (rshift >= RSUM_W'(RND_CLAMP)) ? RND_CLAMP : rshift[RND_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rc_reg    <= rc_next;
            zero5_reg <= zero4_reg;
            div3_reg  <= (rnd4_reg == RND_DIV3);
        end
    end

    // stage 6: reciprocal divide by three and final clamp
    assign recip_prod = (2*RND_W)'(rc_reg) * (2*RND_W)'(DIV3_RECIP);

    always_comb
    begin
        q = div3_reg ? RND_W'(recip_prod >> DIV3_SHIFT) : rc_reg;
        if (zero5_reg)
        begin
            pixel_next = '0;
        end
        else if (q > RND_W'(PIX_MAX))
        begin
            pixel_next = PIX_MAX;
        end
        else
        begin
            pixel_next = q[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

// File: hdl/bayer_quad_bin_to_mono.sv
// bayer_quad_bin_to_mono: top level of the 2x2 bayer quad to mono pixel binner
// depends on bqb_pkg, bqb_regs, bqb_lane, bqb_merge and bqb_scale
//
//   channel   signals                                   beat
//   -------   ---------------------------------------   ---------------------------
//   sample    sample_valid / sample_stall                one quad, four raw samples
//   pixel     pixel_valid / pixel_stall                  one mono_pixel
//   config    psel penable pwrite paddr pwdata prdata    one 64-bit register access
//
// one quad per clock sustained while pixel_stall stays low; each beat passes 7 register
// stages, and pixel_valid rises as the beat reaches the output register
// the path is the four lanes (subtract, 17x17 gain multiply, clip), the merge adder
// tree and the 32x24 scale multiply followed by rounding and the divide-by-three step
// reset clears the stage valid bits and loads the register defaults; no clearing pass
// a stall on pixel only backs up into sample once every stage holds a beat
`timescale 1ns / 1ps

module bayer_quad_bin_to_mono
    import bqb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  logic [SAMPLE_W-1:0]   sample_top_left,
    input  logic [SAMPLE_W-1:0]   sample_top_right,
    input  logic [SAMPLE_W-1:0]   sample_bottom_left,
    input  logic [SAMPLE_W-1:0]   sample_bottom_right,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output logic [PIX_W-1:0]      mono_pixel,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t                    cfg;
    logic [PIPE_STAGES-1:0]  v_reg;
    logic [PIPE_STAGES-1:0]  v_next;
    logic [PIPE_STAGES:0]    rdy;
    logic [SAMPLE_W-1:0]     samples [LANES];
    lane_res_t               lres [LANES];
    scale_op_t               sop;

    assign pready = 1'b1;

    // configuration registers
    bqb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // stage occupancy: a stage loads when it is empty or its successor moves on
    always_comb
    begin
        rdy[PIPE_STAGES] = !pixel_stall;
        for (int i = PIPE_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
        v_next[0] = rdy[0] ? sample_valid : v_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            v_next[i] = rdy[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign sample_stall = !rdy[0];
    assign pixel_valid  = v_reg[PIPE_STAGES-1];

    // quad positions in cfa_pattern order
    assign samples[0] = sample_top_left;
    assign samples[1] = sample_top_right;
    assign samples[2] = sample_bottom_left;
    assign samples[3] = sample_bottom_right;

    // per position lanes
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        bqb_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .LANE        (g)
        ) u_lane (
            .clk    (clk),
            .en     (rdy[2:0]),
            .cfg    (cfg),
            .sample (samples[g]),
            .res    (lres[g])
        );
    end

    // lane merge
    bqb_merge u_merge (
        .clk (clk),
        .en  (rdy[3]),
        .cfg (cfg),
        .res (lres),
        .sop (sop)
    );

    // scale, round and clamp
    bqb_scale u_scale (
        .clk   (clk),
        .en    (rdy[6:4]),
        .cfg   (cfg),
        .sop   (sop),
        .pixel (mono_pixel)
    );

    // an accepted quad always occupies the first stage next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> v_reg[0])
        else $error("accepted quad did not enter the first stage");

    // an empty output register never holds back the sample side
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[PIPE_STAGES-1] |-> !sample_stall)
        else $error("sample stalled while output register empty");

    // a luma mode write lands in the register
    a_luma_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[CFG_ADDR_W-1:3] == REG_LUMA_MODE))
        |=> (cfg.luma_mode == $past(pwdata[0])))
        else $error("luma mode write lost");

endmodule
